FILE: hw/rtl/integer_field_formatter_assert.svh
// ----------------------------------------------------------------------------
// Integer field formatter assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define IFF_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// check that a condition never holds outside reset
`define IFF_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define IFF_ASSERT_CLK(name, prop, msg)
`define IFF_ASSERT_NEVER(name, cond, msg)
`endif
`endif

FILE: hw/rtl/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared constants, codes, types and the digit-to-ASCII function.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int IFF_MAX_WIDTH_DEF = 64;
    localparam int IFF_VAL_W         = 64;
    localparam int IFF_CNT_W         = 7;
    localparam int IFF_NDIG          = 22;
    localparam int IFF_DIG_IDX_W     = $clog2(IFF_NDIG);
    localparam int IFF_ND_W          = $clog2(IFF_NDIG + 1);
    localparam int IFF_BCD_DIG       = 20;
    localparam int IFF_HEX_DIG       = 16;

    // conversion kinds
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;

    // argument sizes
    localparam logic [1:0] SZ_SHORT = 2'd0;
    localparam logic [1:0] SZ_INT   = 2'd1;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [IFF_NDIG-1:0][3:0] iff_digits_t;

    typedef struct packed {
        logic                 start;
        logic [IFF_CNT_W-1:0] nbits;
    } iff_conv_req_t;

    // field layout as position boundaries along the output
    typedef struct packed {
        logic [IFF_CNT_W-1:0] b_sign;
        logic [IFF_CNT_W-1:0] b_pfx;
        logic [IFF_CNT_W-1:0] b_zero;
        logic [IFF_CNT_W-1:0] b_dig;
        logic [IFF_CNT_W-1:0] b_trail;
        logic [IFF_CNT_W-1:0] n_chars;
        logic [7:0]           sign_ch;
        logic [7:0]           x_ch;
        logic                 upper;
    } iff_layout_t;

    typedef struct packed {
        logic        start;
        iff_layout_t lay;
    } iff_emit_req_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
            return CH_ZERO + {4'b0, d};
        else
            return base_ch + {4'b0, d} - 8'd10;
    endfunction

endpackage

FILE: hw/rtl/iff_bcd_conv.sv
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 unit: one argument bit per cycle into twenty BCD digits.
// ----------------------------------------------------------------------------
module iff_bcd_conv (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iff_pkg::iff_conv_req_t                req,
    input  logic [iff_pkg::IFF_VAL_W-1:0]         bin,
    output logic                                  busy,
    output logic [iff_pkg::IFF_BCD_DIG*4-1:0]     bcd
);
    import iff_pkg::*;

    logic                       busy_reg;
    logic [IFF_CNT_W-1:0]       cnt_reg;
    logic [IFF_VAL_W-1:0]       sh_reg;
    logic [IFF_BCD_DIG*4-1:0]   bcd_reg;
    logic [IFF_BCD_DIG*4-1:0]   bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < IFF_BCD_DIG; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // count down the argument bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - IFF_CNT_W'(1);
            if (cnt_reg == IFF_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // shift the next bit into the digit register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sh_reg  <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[IFF_VAL_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[IFF_BCD_DIG*4-2:0], sh_reg[IFF_VAL_W-1]};
        end
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

FILE: hw/rtl/iff_emit.sv
// ----------------------------------------------------------------------------
// Character emitter
// Walks the field one position per beat and drives the output register.
// ----------------------------------------------------------------------------
module iff_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iff_pkg::iff_emit_req_t req,
    input  iff_pkg::iff_digits_t  digits,
    input  logic                  out_stall,
    output logic                  busy,
    output logic                  out_valid,
    output logic [7:0]            ch,
    output logic                  has_char,
    output logic                  last
);
    import iff_pkg::*;

    logic                   busy_reg;
    logic [IFF_CNT_W-1:0]   pos_reg;
    iff_layout_t            lay_reg;
    logic                   out_valid_reg;
    logic [7:0]             ch_reg;
    logic                   has_char_reg;
    logic                   last_reg;

    logic [IFF_CNT_W-1:0]   dig_pos;
    logic [IFF_DIG_IDX_W-1:0] dig_sel;
    logic [3:0]             dig_val;
    logic [7:0]             pos_ch;
    logic                   load_ok;
    logic                   emit_now;
    logic                   is_empty;
    logic                   is_last;

    // pick the digit for this position, most significant first
    always_comb
    begin
        dig_pos = lay_reg.b_trail - IFF_CNT_W'(1) - pos_reg;
        dig_sel = dig_pos[IFF_DIG_IDX_W-1:0];
        dig_val = (dig_pos < IFF_CNT_W'(IFF_NDIG)) ? digits[dig_sel] : 4'd0;
    end

    // map the position onto its segment of the field
    always_comb
    begin
        priority if (pos_reg < lay_reg.b_sign)
            pos_ch = CH_SPACE;
        else if (pos_reg < lay_reg.b_pfx)
            pos_ch = lay_reg.sign_ch;
        else if (pos_reg < lay_reg.b_zero)
            pos_ch = (pos_reg == lay_reg.b_pfx) ? CH_ZERO : lay_reg.x_ch;
        else if (pos_reg < lay_reg.b_dig)
            pos_ch = CH_ZERO;
        else if (pos_reg < lay_reg.b_trail)
            pos_ch = digit_ascii(dig_val, lay_reg.upper);
        else
            pos_ch = CH_SPACE;
    end

    assign load_ok  = !out_valid_reg || !out_stall;
    assign emit_now = busy_reg && load_ok;
    assign is_empty = (lay_reg.n_chars == '0);
    assign is_last  = is_empty || (pos_reg == lay_reg.n_chars - IFF_CNT_W'(1));

    // advance the position and track the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (emit_now)
            begin
                pos_reg <= pos_reg + IFF_CNT_W'(1);
                if (is_last)
                    busy_reg <= 1'b0;
            end

            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the layout and load the beat payload
    always_ff @(posedge clk)
    begin
        if (req.start)
            lay_reg <= req.lay;
        if (emit_now)
        begin
            ch_reg       <= is_empty ? CH_NUL : pos_ch;
            has_char_reg <= !is_empty;
            last_reg     <= is_last;
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign ch        = ch_reg;
    assign has_char  = has_char_reg;
    assign last      = last_reg;

endmodule

FILE: hw/rtl/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats one integer argument as a printf-style field, one character a beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid / in_stall   | value, op, size, flags, width, precision
//  out     | source    | out_valid / out_stall | ch, has_char, last
//
//  After an accept the item passes the load, count, layout, bound and go steps and then
//  the emitter. Decimal adds a conversion step between load and count, where the BCD shift
//  unit runs one argument bit per cycle over 16, 32 or 64 bits by size.
//  in_stall is high from the cycle after an accept until the sequencer returns to idle
//  once the last output beat is loaded. out_stall freezes the emitter; the final beat
//  may wait while the next item enters. Reset is asynchronous and clears all control state.
// ----------------------------------------------------------------------------
`include "integer_field_formatter_assert.svh"

module integer_field_formatter #(
    parameter int MAX_WIDTH = iff_pkg::IFF_MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [iff_pkg::IFF_VAL_W-1:0] value,
    input  logic [2:0]                    op,
    input  logic [1:0]                    size,
    input  logic                          left_justify,
    input  logic                          force_sign,
    input  logic                          space_sign,
    input  logic                          alternate,
    input  logic                          zero_pad,
    input  logic [6:0]                    width,
    input  logic                          has_precision,
    input  logic [5:0]                    precision,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    ch,
    output logic                          has_char,
    output logic                          last
);
    import iff_pkg::*;

    localparam logic [6:0] MaxW    = 7'(MAX_WIDTH);
    localparam logic [5:0] MaxPrec = 6'(MAX_WIDTH - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_COUNT,
        ST_LAYOUT,
        ST_BOUND,
        ST_GO,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic                   accept;
    logic [IFF_VAL_W-1:0]   mask_in;
    logic [IFF_VAL_W-1:0]   v_in;
    logic [IFF_VAL_W-1:0]   mag_in;
    logic                   sgn_in;
    logic                   neg_in;
    logic                   oct_in;
    logic                   hex_in;
    logic [6:0]             width_in;
    logic [5:0]             prec_in;

    logic [IFF_VAL_W-1:0]   mag_reg;
    logic                   mzero_reg;
    logic                   neg_reg;
    logic                   sgn_reg;
    logic                   oct_reg;
    logic                   hex_reg;
    logic                   upper_reg;
    logic                   left_reg;
    logic                   plus_reg;
    logic                   space_reg;
    logic                   alt_reg;
    logic                   zpad_reg;
    logic                   hasp_reg;
    logic [6:0]             width_reg;
    logic [5:0]             prec_reg;
    logic [1:0]             size_reg;

    logic [IFF_ND_W-1:0]    nd_reg;
    logic [IFF_CNT_W-1:0]   zeros_reg;
    logic                   xflag_reg;
    logic                   sflag_reg;
    logic [7:0]             sign_ch_reg;
    logic [IFF_CNT_W-1:0]   total_reg;
    iff_layout_t            lay_reg;

    logic [IFF_CNT_W-1:0]   nbits;
    logic [IFF_VAL_W-1:0]   aligned;
    logic [IFF_VAL_W+1:0]   mag_ext;
    iff_digits_t            digits;
    logic [IFF_ND_W-1:0]    top_nd;
    logic [IFF_CNT_W-1:0]   nd7;
    logic [IFF_CNT_W-1:0]   zeros_c;
    logic [IFF_CNT_W-1:0]   total_c;
    logic [7:0]             sign_ch_c;
    logic                   xflag_c;
    logic                   sflag_c;
    iff_layout_t            lay_c;

    iff_conv_req_t          conv_req;
    logic                   conv_busy;
    logic [IFF_BCD_DIG*4-1:0] bcd;
    iff_emit_req_t          emit_req;
    logic                   emit_busy;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // truncate or sign-extend the argument and take its magnitude
    always_comb
    begin
        unique case (size)
            SZ_SHORT: mask_in = {{(IFF_VAL_W-16){1'b0}}, 16'hFFFF};
            SZ_INT:   mask_in = {{(IFF_VAL_W-32){1'b0}}, 32'hFFFF_FFFF};
            default:  mask_in = '1;
        endcase
        sgn_in = (op == OP_SDEC);
        oct_in = (op == OP_OCT);
        hex_in = (op == OP_HEXL) || (op == OP_HEXU);
        v_in   = value & mask_in;
        if (sgn_in && (size == SZ_SHORT) && v_in[15])
            v_in = v_in | ~mask_in;
        if (sgn_in && (size == SZ_INT) && v_in[31])
            v_in = v_in | ~mask_in;
        neg_in   = sgn_in && v_in[IFF_VAL_W-1];
        mag_in   = neg_in ? (~v_in + IFF_VAL_W'(1)) : v_in;
        width_in = (width > MaxW) ? MaxW : width;
        if (!has_precision)
            prec_in = 6'd1;
        else
            prec_in = (precision > MaxPrec) ? MaxPrec : precision;
    end

    // align the magnitude to the top for the BCD unit
    always_comb
    begin
        unique case (size_reg)
            SZ_SHORT:
            begin
                nbits   = IFF_CNT_W'(16);
                aligned = mag_reg << (IFF_VAL_W - 16);
            end
            SZ_INT:
            begin
                nbits   = IFF_CNT_W'(32);
                aligned = mag_reg << (IFF_VAL_W - 32);
            end
            default:
            begin
                nbits   = IFF_CNT_W'(IFF_VAL_W);
                aligned = mag_reg;
            end
        endcase
    end

    // gather the digits of the chosen base, least significant first
    always_comb
    begin
        mag_ext = {2'b00, mag_reg};
        digits  = '0;
        if (oct_reg)
        begin
            for (int i = 0; i < IFF_NDIG; i++)
                digits[i] = {1'b0, mag_ext[3*i +: 3]};
        end
        else if (hex_reg)
        begin
            for (int i = 0; i < IFF_HEX_DIG; i++)
                digits[i] = mag_reg[4*i +: 4];
        end
        else
        begin
            for (int i = 0; i < IFF_BCD_DIG; i++)
                digits[i] = bcd[4*i +: 4];
        end
    end

    // find the highest nonzero digit
    always_comb
    begin
        top_nd = IFF_ND_W'(1);
        for (int i = 0; i < IFF_NDIG; i++)
        begin
            if (digits[i] != 4'd0)
                top_nd = IFF_ND_W'(i + 1);
        end
    end

    // work out sign, prefix and precision zeros
    always_comb
    begin
        nd7     = IFF_CNT_W'(nd_reg);
        zeros_c = ({1'b0, prec_reg} > nd7) ? {1'b0, prec_reg} - nd7 : '0;
        if (oct_reg && alt_reg && (zeros_c == '0) && !((nd_reg != '0) && mzero_reg))
            zeros_c = IFF_CNT_W'(1);
        xflag_c = hex_reg && alt_reg && !mzero_reg;
        sflag_c = sgn_reg && (neg_reg || plus_reg || space_reg);
        if (neg_reg)
            sign_ch_c = CH_MINUS;
        else if (plus_reg)
            sign_ch_c = CH_PLUS;
        else
            sign_ch_c = CH_SPACE;
        total_c = IFF_CNT_W'(sflag_c) + {5'b0, xflag_c, 1'b0} + zeros_c + nd7;
    end

    // place the padding and set the segment boundaries
    always_comb
    begin
        logic [IFF_CNT_W-1:0] pad;
        logic [IFF_CNT_W-1:0] lead;
        logic [IFF_CNT_W-1:0] zfill;
        logic [IFF_CNT_W-1:0] trail;
        logic                 zmode;
        pad   = (width_reg > total_reg) ? width_reg - total_reg : '0;
        zmode = zpad_reg && !hasp_reg;
        lead  = (!left_reg && !zmode) ? pad : '0;
        zfill = (!left_reg && zmode) ? pad : '0;
        trail = left_reg ? pad : '0;
        lay_c.b_sign  = lead;
        lay_c.b_pfx   = lead + IFF_CNT_W'(sflag_reg);
        lay_c.b_zero  = lay_c.b_pfx + {5'b0, xflag_reg, 1'b0};
        lay_c.b_dig   = lay_c.b_zero + zfill + zeros_reg;
        lay_c.b_trail = lay_c.b_dig + IFF_CNT_W'(nd_reg);
        lay_c.n_chars = lay_c.b_trail + trail;
        lay_c.sign_ch = sign_ch_reg;
        lay_c.x_ch    = upper_reg ? CH_UX : CH_LX;
        lay_c.upper   = upper_reg;
    end

    // sequence one item through the shared units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            unique case (state_reg)
                ST_IDLE:   if (accept) state_reg <= ST_LOAD;
                ST_LOAD:   state_reg <= (oct_reg || hex_reg) ? ST_COUNT : ST_CONV;
                ST_CONV:   if (!conv_busy) state_reg <= ST_COUNT;
                ST_COUNT:  state_reg <= ST_LAYOUT;
                ST_LAYOUT: state_reg <= ST_BOUND;
                ST_BOUND:  state_reg <= ST_GO;
                ST_GO:     state_reg <= ST_EMIT;
                ST_EMIT:   if (!emit_busy) state_reg <= ST_IDLE;
            endcase
        end
    end

    // capture the item and the per-stage results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg   <= mag_in;
            mzero_reg <= (v_in == '0);
            neg_reg   <= neg_in;
            sgn_reg   <= sgn_in;
            oct_reg   <= oct_in;
            hex_reg   <= hex_in;
            upper_reg <= (op == OP_HEXU);
            left_reg  <= left_justify;
            plus_reg  <= force_sign;
            space_reg <= space_sign;
            alt_reg   <= alternate;
            zpad_reg  <= zero_pad;
            hasp_reg  <= has_precision;
            width_reg <= width_in;
            prec_reg  <= prec_in;
            size_reg  <= size;
        end
        if (state_reg == ST_COUNT)
            nd_reg <= (mzero_reg && (prec_reg == '0)) ? '0 : top_nd;
        if (state_reg == ST_LAYOUT)
        begin
            zeros_reg   <= zeros_c;
            xflag_reg   <= xflag_c;
            sflag_reg   <= sflag_c;
            sign_ch_reg <= sign_ch_c;
            total_reg   <= total_c;
        end
        if (state_reg == ST_BOUND)
            lay_reg <= lay_c;
    end

    assign conv_req.start = (state_reg == ST_LOAD) && !oct_reg && !hex_reg;
    assign conv_req.nbits = nbits;
    assign emit_req.start = (state_reg == ST_GO);
    assign emit_req.lay   = lay_reg;

    iff_bcd_conv u_bcd_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .bin   (aligned),
        .busy  (conv_busy),
        .bcd   (bcd)
    );

    iff_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (emit_req),
        .digits    (digits),
        .out_stall (out_stall),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .ch        (ch),
        .has_char  (has_char),
        .last      (last)
    );

    // check sequencing of the shared units
    `IFF_ASSERT_CLK(a_accept_when_free, (accept) |-> (!conv_busy && !emit_busy), "item taken while a unit is busy")
    `IFF_ASSERT_CLK(a_conv_in_conv_state, (conv_busy) |-> (state_reg == ST_CONV), "BCD unit runs outside its step")
    `IFF_ASSERT_NEVER(a_units_exclusive, conv_busy && emit_busy, "BCD unit and emitter overlap")
    `IFF_ASSERT_CLK(a_empty_beat_last, (out_valid && !has_char) |-> last, "empty beat not marked last")

endmodule

FILE: tb/field_format_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer field formatter checker
// Watches both channels of the formatter. Every accepted input beat is turned
// into the characters the field should produce, following printf rules for
// integer conversions. Every accepted output beat is compared field by field
// against the oldest expected character.
// ----------------------------------------------------------------------------
module field_format_checker #(
    parameter int MAX_WIDTH = iff_pkg::IFF_MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] value,
    input  logic [2:0]  op,
    input  logic [1:0]  size,
    input  logic        left_justify,
    input  logic        force_sign,
    input  logic        space_sign,
    input  logic        alternate,
    input  logic        zero_pad,
    input  logic [6:0]  width,
    input  logic        has_precision,
    input  logic [5:0]  precision,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  ch,
    input  logic        has_char,
    input  logic        last,
    output int          mismatches,
    output int          pending,
    output int          fields_seen,
    output int          beats_seen
);
    import iff_pkg::*;

    localparam int REPORT_CAP = 40;
    // most characters one field can produce
    localparam int BUF_LEN    = 64;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } char_beat_t;

    char_beat_t expected_chars[$];

    initial
    begin
        mismatches  = 0;
        pending     = 0;
        fields_seen = 0;
        beats_seen  = 0;
    end

    // print one line per mismatch, up to a cap, and count every one
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("[%0t] ERROR %s", $time, what);
    endtask

    // build the characters of one formatted field and queue them
    function automatic void format_field(
        input logic [63:0] raw,
        input logic [2:0]  kind,
        input logic [1:0]  sz,
        input logic        lj,
        input logic        plus,
        input logic        spc,
        input logic        alt,
        input logic        zp,
        input logic [6:0]  wd,
        input logic        hp,
        input logic [5:0]  pr
    );
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] base;
        logic [63:0] rem;
        logic [3:0]  digs[0:21];
        logic [7:0]  sign_ch;
        logic [7:0]  x_ch;
        logic [7:0]  text[$];
        logic        is_signed;
        logic        octal;
        logic        hex;
        logic        upper;
        logic        neg;
        logic        zero_fill;
        int          fw;
        int          min_digits;
        int          nd;
        int          zeros;
        int          total;
        int          pad;
        int          n;

        // spare kinds format as unsigned decimal
        if (kind > OP_HEXU)
            kind = OP_UDEC;
        is_signed = (kind == OP_SDEC);
        octal     = (kind == OP_OCT);
        hex       = (kind == OP_HEXL) || (kind == OP_HEXU);
        upper     = (kind == OP_HEXU);
        base      = octal ? 64'd8 : (hex ? 64'd16 : 64'd10);

        // clamp width and precision
        fw = (int'(wd) > MAX_WIDTH) ? MAX_WIDTH : int'(wd);
        if (!hp)
            min_digits = 1;
        else if (int'(pr) > MAX_WIDTH - 2)
            min_digits = MAX_WIDTH - 2;
        else
            min_digits = int'(pr);

        // truncate to the argument size, sign-extend for signed decimal
        case (sz)
            SZ_SHORT: mask = 64'h0000_0000_0000_FFFF;
            SZ_INT:   mask = 64'h0000_0000_FFFF_FFFF;
            default:  mask = '1;
        endcase
        v = raw & mask;
        if (is_signed && (sz == SZ_SHORT || sz == SZ_INT) && ((v & ((mask >> 1) + 64'd1)) != 0))
            v = v | ~mask;
        neg = is_signed && v[63];
        mag = neg ? (64'd0 - v) : v;

        if (neg)
            sign_ch = CH_MINUS;
        else if (is_signed && plus)
            sign_ch = CH_PLUS;
        else if (is_signed && spc)
            sign_ch = CH_SPACE;
        else
            sign_ch = CH_NUL;

        // digits, least significant first; a zero value with zero precision has none
        nd = 0;
        if (!(mag == 0 && min_digits == 0))
        begin
            t = mag;
            do
            begin
                rem = t % base;
                digs[nd] = rem[3:0];
                nd++;
                t = t / base;
            end
            while (t != 0);
        end

        zeros = (min_digits > nd) ? min_digits - nd : 0;
        // octal alternate form needs one leading zero unless a zero is already there
        if (octal && alt && zeros == 0 && !(nd > 0 && mag == 0))
            zeros = 1;
        x_ch = (hex && alt && mag != 0) ? (upper ? CH_UX : CH_LX) : CH_NUL;

        total = ((sign_ch != CH_NUL) ? 1 : 0) + ((x_ch != CH_NUL) ? 2 : 0) + zeros + nd;
        pad = (fw > total) ? fw - total : 0;
        zero_fill = !lj && zp && !hp;

        // lay out: pad, sign, prefix, zero fill, precision zeros, digits, right pad
        if (!lj && !zero_fill)
            repeat (pad) text.push_back(CH_SPACE);
        if (sign_ch != CH_NUL)
            text.push_back(sign_ch);
        if (x_ch != CH_NUL)
        begin
            text.push_back(CH_ZERO);
            text.push_back(x_ch);
        end
        if (zero_fill)
            repeat (pad) text.push_back(CH_ZERO);
        repeat (zeros) text.push_back(CH_ZERO);
        for (int k = nd - 1; k >= 0; k--)
        begin
            if (digs[k] < 4'd10)
                text.push_back(CH_ZERO + {4'b0, digs[k]});
            else
                text.push_back((upper ? CH_UA : CH_LA) + {4'b0, digs[k]} - 8'd10);
        end
        if (lj)
            repeat (pad) text.push_back(CH_SPACE);

        // queue the beats; an empty field still yields one marker beat
        n = (text.size() > BUF_LEN) ? BUF_LEN : text.size();
        if (n == 0)
            expected_chars.push_back('{ch: CH_NUL, has_char: 1'b0, last: 1'b1});
        else
            for (int i = 0; i < n; i++)
                expected_chars.push_back('{ch: text[i], has_char: 1'b1, last: (i == n - 1)});
    endfunction

    // predict on each input beat, compare on each output beat
    always @(posedge clk)
    begin
        char_beat_t exp_beat;
        if (rst_n && in_valid && !in_stall)
        begin
            format_field(value, op, size, left_justify, force_sign, space_sign, alternate,
                         zero_pad, width, has_precision, precision);
            fields_seen++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("output beat with nothing expected: ch %02h has_char %0b last %0b",
                                          ch, has_char, last));
            else
            begin
                exp_beat = expected_chars.pop_front();
                if (ch !== exp_beat.ch)
                    report_mismatch($sformatf("beat %0d ch: got %02h expected %02h",
                                              beats_seen, ch, exp_beat.ch));
                if (has_char !== exp_beat.has_char)
                    report_mismatch($sformatf("beat %0d has_char: got %0b expected %0b",
                                              beats_seen, has_char, exp_beat.has_char));
                if (last !== exp_beat.last)
                    report_mismatch($sformatf("beat %0d last: got %0b expected %0b",
                                              beats_seen, last, exp_beat.last));
            end
        end
        pending = expected_chars.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives printf-style integer conversion requests into the formatter: a short
// directed set of corner fields, then random fields under four handshake
// pressure phases. A checker beside the block predicts and compares the
// character stream; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import iff_pkg::*;

    localparam int RANDOM_PER_PHASE = 111;
    localparam int DRAIN_CYCLES     = 250;

    // size codes not named in the package
    localparam logic [1:0] SZ_LONG   = 2'd2;
    localparam logic [1:0] SZ_UNUSED = 2'd3;
    // spare conversion codes
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    // flag bits for building directed fields
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ALT   = 5'b00010;
    localparam logic [4:0] F_ZERO  = 5'b00001;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  op;
        logic [1:0]  size;
        logic [4:0]  flags;
        logic [6:0]  width;
        logic        has_precision;
        logic [5:0]  precision;
    } fmt_request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value;
    logic [2:0]  op;
    logic [1:0]  size;
    logic        left_justify;
    logic        force_sign;
    logic        space_sign;
    logic        alternate;
    logic        zero_pad;
    logic [6:0]  width;
    logic        has_precision;
    logic [5:0]  precision;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  ch;
    logic        has_char;
    logic        last;

    int mismatches;
    int pending;
    int fields_seen;
    int beats_seen;
    int idle_pct;
    int stall_pct;

    integer_field_formatter dut (.*);

    field_format_checker u_checker (.*);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard limit on run time
    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver stalls at the current phase rate
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic fmt_request_t spec(input logic [63:0] val, input logic [2:0] kind,
                                          input logic [1:0] sz, input logic [4:0] flags,
                                          input int wd, input logic hp, input int pr);
        fmt_request_t req;
        req.value         = val;
        req.op            = kind;
        req.size          = sz;
        req.flags         = flags;
        req.width         = wd[6:0];
        req.has_precision = hp;
        req.precision     = pr[5:0];
        return req;
    endfunction

    // random field: mostly legal codes and short widths, some values aimed at sign boundaries
    function automatic fmt_request_t random_field();
        fmt_request_t req;
        logic [63:0]  r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: req.value = r;
            3, 4:    req.value = r >> $urandom_range(63);
            5:       req.value = 64'd0;
            6:       req.value = 64'($urandom_range(999));
            default:
                case ($urandom_range(6))
                    0: req.value = {r[63:16], 16'h7FFF};
                    1: req.value = {r[63:16], 16'h8000};
                    2: req.value = {r[63:32], 32'h7FFF_FFFF};
                    3: req.value = {r[63:32], 32'h8000_0000};
                    4: req.value = 64'h7FFF_FFFF_FFFF_FFFF;
                    5: req.value = 64'h8000_0000_0000_0000;
                    default: req.value = '1;
                endcase
        endcase
        if ($urandom_range(19) == 0)
            req.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else
            req.op = 3'($urandom_range(OP_HEXU, OP_SDEC));
        if ($urandom_range(19) == 0)
            req.size = SZ_UNUSED;
        else
            req.size = 2'($urandom_range(SZ_LONG, SZ_SHORT));
        for (int i = 0; i < 5; i++)
            req.flags[i] = ($urandom_range(99) < 35);
        case ($urandom_range(19))
            19:      req.width = 7'($urandom_range(127, 65));
            13, 14, 15, 16, 17, 18:
                     req.width = 7'($urandom_range(64, 13));
            default: req.width = 7'($urandom_range(12));
        endcase
        req.has_precision = 1'($urandom_range(1));
        if ($urandom_range(9) < 7)
            req.precision = 6'($urandom_range(8));
        else
            req.precision = 6'($urandom_range(63, 9));
        return req;
    endfunction

    // present one beat after optional idle cycles and hold it until accepted
    task automatic send_field(input fmt_request_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        value         <= req.value;
        op            <= req.op;
        size          <= req.size;
        left_justify  <= req.flags[4];
        force_sign    <= req.flags[3];
        space_sign    <= req.flags[2];
        alternate     <= req.flags[1];
        zero_pad      <= req.flags[0];
        width         <= req.width;
        has_precision <= req.has_precision;
        precision     <= req.precision;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        phase_idle  = '{0, 46, 0, 36};
        phase_stall = '{0, 0, 46, 36};

        // known values on every input from time zero
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        value         <= '0;
        op            <= OP_SDEC;
        size          <= SZ_SHORT;
        left_justify  <= 1'b0;
        force_sign    <= 1'b0;
        space_sign    <= 1'b0;
        alternate     <= 1'b0;
        zero_pad      <= 1'b0;
        width         <= '0;
        has_precision <= 1'b0;
        precision     <= '0;
        idle_pct       = 0;
        stall_pct     <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners, no idling
        send_field(spec(64'd0, OP_SDEC, SZ_INT, F_NONE, 0, 1'b0, 0));
        send_field(spec(64'd0, OP_UDEC, SZ_INT, F_NONE, 0, 1'b1, 0));
        send_field(spec(64'hABCD_0000_0000_FFFF, OP_SDEC, SZ_SHORT, F_NONE, 0, 1'b0, 0));
        send_field(spec(64'h8000_0000_0000_0000, OP_SDEC, SZ_LONG, F_NONE, 0, 1'b0, 0));
        send_field(spec('1, OP_UDEC, SZ_LONG, F_NONE, 0, 1'b0, 0));
        send_field(spec('1, OP_OCT, SZ_LONG, F_ALT, 0, 1'b0, 0));
        send_field(spec(64'd0, OP_OCT, SZ_INT, F_ALT, 0, 1'b1, 0));
        send_field(spec(64'd8, OP_OCT, SZ_INT, F_ALT, 0, 1'b0, 0));
        send_field(spec(64'hDEAD_BEEF, OP_HEXL, SZ_INT, F_ALT | F_ZERO, 20, 1'b0, 0));
        send_field(spec(64'd0, OP_HEXU, SZ_INT, F_ALT, 0, 1'b0, 0));
        send_field(spec(64'd42, OP_SDEC, SZ_INT, F_PLUS | F_LEFT, 8, 1'b0, 0));
        send_field(spec(64'd42, OP_SDEC, SZ_INT, F_SPACE | F_ZERO, 8, 1'b0, 0));
        send_field(spec(-64'sd42, OP_SDEC, SZ_INT, F_ZERO, 10, 1'b1, 5));
        send_field(spec(64'd7, OP_SDEC, SZ_SHORT, F_PLUS | F_SPACE, 0, 1'b0, 0));
        send_field(spec(64'd7, OP_UDEC, SZ_SHORT, F_PLUS | F_SPACE, 4, 1'b0, 0));
        send_field(spec(64'hFFFF_8000, OP_SDEC, SZ_SHORT, F_ZERO, 64, 1'b0, 0));
        send_field(spec(64'hBEEF, OP_HEXU, SZ_SHORT, F_LEFT | F_ALT, 127, 1'b0, 0));
        send_field(spec(64'h1234, OP_HEXL, SZ_LONG, F_ALT, 0, 1'b1, 63));
        send_field(spec(-64'sd1, OP_SDEC, SZ_LONG, F_NONE, 0, 1'b1, 62));
        send_field(spec(64'd1234, OP_SPARE_LO, SZ_INT, F_PLUS, 0, 1'b0, 0));
        send_field(spec(64'd1234, OP_SPARE_MID, SZ_INT, F_SPACE, 6, 1'b0, 0));
        send_field(spec('1, OP_SPARE_HI, SZ_SHORT, F_NONE, 0, 1'b0, 0));
        send_field(spec('1, OP_SDEC, SZ_UNUSED, F_NONE, 0, 1'b0, 0));
        send_field(spec(64'hFFFF_FFFF_8000_0000, OP_SDEC, SZ_INT, F_NONE, 12, 1'b0, 0));
        send_field(spec(64'd0, OP_SDEC, SZ_INT, F_PLUS, 0, 1'b1, 0));
        send_field(spec(64'd0, OP_HEXL, SZ_INT, F_LEFT, 5, 1'b1, 0));

        // random fields, one phase per idle/stall setting
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct   = phase_idle[ph];
            stall_pct <= phase_stall[ph];
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_field(random_field());
        end
        in_valid <= 1'b0;

        // drain, then watch for stray beats
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d fields and %0d characters: corners, then random", fields_seen,
                 beats_seen);
        $display("fields under free flow, sender gaps, receiver stalls and both together");
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/iff_pkg.sv
hw/rtl/iff_bcd_conv.sv
hw/rtl/iff_emit.sv
hw/rtl/integer_field_formatter.sv
tb/field_format_checker.sv
tb/tb_top.sv
